FILE: src/mdh_pkg.sv
// Shared types and constants for the midpoint displacement height map.
// Used by the channel interfaces, the arithmetic unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mdh_pkg;

    // Field widths of the channels and internal data paths.
    localparam int CMD_W       = 2;
    localparam int VAL_W       = 16;
    localparam int COORD_W     = 7;
    localparam int DISP_W      = 17;
    localparam int ACC_W       = 19;
    localparam int MUL_W       = 19;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int RECIP_SHIFT = 20;
    localparam int BLUR_W      = 2;
    localparam int CFG_IDX_W   = 1;

    // Commands carried by the input channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_RAND    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR  = 1'b1;

    localparam logic [VAL_W-1:0]  NOISE_RESET = 16'd32768;
    localparam logic [BLUR_W-1:0] BLUR_RESET  = 2'd2;
    localparam logic [DISP_W-1:0] DISP_UNIT   = 17'h10000;

    // Reciprocals in units of 2^-RECIP_SHIFT, rounded down.
    localparam logic [MUL_W-1:0] RECIP3 = 19'd349525;
    localparam logic [MUL_W-1:0] RECIP5 = 19'd209715;
    localparam logic [MUL_W-1:0] RECIP8 = 19'd131072;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MS_DISP,
        MS_LEVEL,
        MS_DIV
    } t_mul_src;

    // Neighbor count of a smoothing point.
    typedef enum logic [1:0] {
        W_THREE,
        W_FIVE,
        W_EIGHT
    } t_wsel;

    // Control word from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic     acc_clr;
        logic     acc_en;
        logic     mul_en;
        t_mul_src mul_src;
        logic     mean_en;
        logic     mean_four;
        t_wsel    wsel;
    } t_alu_ctl;

endpackage

`default_nettype wire

FILE: src/mdh_in_if.sv
// Input channel: valid/ready handshake with command, random value and coordinates.
// Depends on mdh_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mdh_in_if import mdh_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VAL_W-1:0]   rand_value;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;

    modport source (output valid, cmd, rand_value, coord_x, coord_y, input ready);
    modport sink   (input valid, cmd, rand_value, coord_x, coord_y, output ready);
endinterface

`default_nettype wire

FILE: src/mdh_out_if.sv
// Output channel: valid/ready handshake carrying a height and the complete flag.
// Depends on mdh_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mdh_out_if import mdh_pkg::*;;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] height;
    logic             complete;

    modport source (output valid, height, complete, input ready);
    modport sink   (input valid, height, complete, output ready);
endinterface

`default_nettype wire

FILE: src/mdh_alu.sv
// Shared arithmetic unit: accumulator, one registered multiplier, displacement
// clamp and reciprocal division with correction. Depends on mdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdh_alu import mdh_pkg::*; (
    input  logic              i_clk,
    input  t_alu_ctl          i_ctl,
    input  logic [VAL_W-1:0]  i_rdata,
    input  logic [VAL_W-1:0]  i_rand,
    input  logic [VAL_W-1:0]  i_noise,
    input  logic [DISP_W-1:0] i_disp,
    output logic [VAL_W-1:0]  o_gen_height,
    output logic [VAL_W-1:0]  o_smooth_height,
    output logic [DISP_W-1:0] o_level_disp
);

    localparam int SW = VAL_W + 3;

    logic [ACC_W-1:0]  r_acc;
    logic [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]  r_mean;

    logic [MUL_W-1:0]  opa;
    logic [MUL_W-1:0]  opb;
    logic [MUL_W-1:0]  recip;
    logic [3:0]        wv;
    logic [VAL_W-1:0]  quot;
    logic [ACC_W-1:0]  qw;
    logic [ACC_W-1:0]  rem;
    logic signed [SW-1:0] v;

    // Reciprocal and divisor for the current neighbor count.
    always_comb begin
        case (i_ctl.wsel)
            W_THREE: begin
                recip = RECIP3;
                wv    = 4'd3;
            end
            W_FIVE: begin
                recip = RECIP5;
                wv    = 4'd5;
            end
            default: begin
                recip = RECIP8;
                wv    = 4'd8;
            end
        endcase
    end

    // Multiplier operand selection.
    always_comb begin
        case (i_ctl.mul_src)
            MS_DISP: begin
                opa = MUL_W'(i_rand);
                opb = MUL_W'(i_disp);
            end
            MS_LEVEL: begin
                opa = MUL_W'(i_noise);
                opb = MUL_W'(i_disp);
            end
            default: begin
                opa = MUL_W'(r_acc);
                opb = recip;
            end
        endcase
    end

    // Accumulator, product and mean registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + ACC_W'(i_rdata);
        end
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(opa) * PROD_W'(opb);
        end
        if (i_ctl.mean_en) begin
            r_mean <= i_ctl.mean_four ? VAL_W'(r_acc >> 2) : VAL_W'(r_acc >> 1);
        end
    end

    // Mean plus scaled random offset, clamped to the height range.
    always_comb begin
        v = signed'({3'b000, r_mean})
          + signed'({2'b00, r_prod[VAL_W +: DISP_W]})
          - signed'({3'b000, i_disp[DISP_W-1:1]});
        if (v < 0) begin
            o_gen_height = '0;
        end else if (v > signed'(SW'(16'hFFFF))) begin
            o_gen_height = '1;
        end else begin
            o_gen_height = v[VAL_W-1:0];
        end
    end

    // Quotient estimate is exact or one low; a single compare fixes it.
    always_comb begin
        quot = r_prod[RECIP_SHIFT +: VAL_W];
        case (i_ctl.wsel)
            W_THREE: qw = (ACC_W'(quot) << 1) + ACC_W'(quot);
            W_FIVE:  qw = (ACC_W'(quot) << 2) + ACC_W'(quot);
            default: qw = ACC_W'(quot) << 3;
        endcase
        rem = r_acc - qw;
        o_smooth_height = (rem >= ACC_W'(wv)) ? quot + VAL_W'(1) : quot;
    end

    assign o_level_disp = r_prod[VAL_W +: DISP_W];

endmodule

`default_nettype wire

FILE: src/midpoint_displacement_heightmap.sv
// Midpoint displacement height map generator with its sequencer and height memory.
// Depends on mdh_pkg, mdh_in_if, mdh_out_if and mdh_alu.
`timescale 1ns / 1ps
`default_nettype none

// The block builds a (GRID_SIZE+1) x (GRID_SIZE+1) map of Q0.16 heights, GRID_SIZE
// a power of two, from random values supplied with command 0: four corners, the
// map centre, then five values per cell and level. A read fetches its height into
// the read data register at its transfer; the read delivery state then moves it to
// the output register, waiting while that register holds an unaccepted result. A
// random value that sets a corner is written at its transfer; any other averages
// two points or four points, each read one at a time from the single read port of
// the height memory, and the result then goes through the shared multiplier. The
// value that ends a level also scales the displacement. After the last level, r_blur
// smoothing passes of GRID_SIZE^2 points run before the next command is taken. The
// memory has no clearing pass; a point must be written before it is read.
module midpoint_displacement_heightmap import mdh_pkg::*; #(
    parameter int GRID_SIZE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mdh_in_if.sink               i_in,
    mdh_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    localparam int CW    = $clog2(GRID_SIZE + 1);
    localparam int LG    = $clog2(GRID_SIZE);
    localparam int SPAN  = GRID_SIZE + 1;
    localparam int DEPTH = SPAN * SPAN;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = (CW > COORD_W) ? CW : COORD_W;
    localparam logic [CW-1:0] GRID = CW'(GRID_SIZE);

    typedef enum logic [2:0] {
        S_IDLE, S_RDOUT, S_GATHER, S_MUL, S_WRITE, S_LEVEL, S_LEVEL_LOAD
    } t_state;

    typedef enum logic [2:0] {
        PH_CORNER, PH_CENTRE, PH_MID, PH_EDGE_Y0, PH_EDGE_Y1, PH_EDGE_X0, PH_EDGE_X1
    } t_phase;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return (AW'(x) << LG) + AW'(x) + AW'(y);
    endfunction

    t_state            r_state;
    t_phase            r_phase;
    logic [1:0]        r_corner;
    logic [CW-1:0]     r_x0;
    logic [CW-1:0]     r_y0;
    logic [CW-1:0]     r_side;
    logic [DISP_W-1:0] r_d;
    logic [BLUR_W-1:0] r_pass;
    logic              r_done;
    logic              r_smooth;
    logic [3:0]        r_k;
    logic              r_pv;
    logic [VAL_W-1:0]  r_rand;
    logic [VAL_W-1:0]  r_noise;
    logic [BLUR_W-1:0] r_blur;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_height;
    logic              r_out_complete;
    logic [VAL_W-1:0]  r_rdata;
    logic [VAL_W-1:0]  r_mem [DEPTH];

    logic              in_acc;
    logic [CW-1:0]     s_eff;
    logic [CW-1:0]     x1;
    logic [CW-1:0]     y1;
    logic [CW-1:0]     mx;
    logic [CW-1:0]     my;
    logic [3:0]        n_pts;
    logic [CW-1:0]     px;
    logic [CW-1:0]     py;
    logic              pt_ok;
    logic [XW-1:0]     xe;
    logic [XW-1:0]     ye;
    logic [CW-1:0]     sx;
    logic [CW-1:0]     sy;
    logic              mem_we;
    logic              mem_ren;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [VAL_W-1:0]  wdata;
    logic [DISP_W-1:0] d_eff;
    t_alu_ctl          alu_ctl;
    logic [VAL_W-1:0]  gen_height;
    logic [VAL_W-1:0]  smooth_height;
    logic [DISP_W-1:0] level_disp;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid    = r_out_valid;
    assign o_out.height   = r_out_height;
    assign o_out.complete = r_out_complete;

    // Cell geometry; the map centre step treats the whole map as one cell.
    assign s_eff = (r_phase == PH_CENTRE) ? GRID : r_side;
    assign x1    = r_x0 + s_eff;
    assign y1    = r_y0 + s_eff;
    assign mx    = r_x0 + (s_eff >> 1);
    assign my    = r_y0 + (s_eff >> 1);
    assign d_eff = (r_phase == PH_CENTRE) ? DISP_UNIT : r_d;

    always_comb begin
        if (r_smooth) begin
            n_pts = 4'd8;
        end else if (r_phase == PH_CENTRE || r_phase == PH_MID) begin
            n_pts = 4'd4;
        end else begin
            n_pts = 4'd2;
        end
    end

    // Point read at step r_k of the gather sweep.
    always_comb begin
        px    = r_x0;
        py    = r_y0;
        pt_ok = 1'b1;
        if (r_smooth) begin
            case (r_k[2:0])
                3'd0: begin
                    px = r_x0 - CW'(1);
                    py = r_y0 - CW'(1);
                    pt_ok = (r_x0 != '0) && (r_y0 != '0);
                end
                3'd1: begin
                    px = r_x0 - CW'(1);
                    pt_ok = (r_x0 != '0);
                end
                3'd2: begin
                    px = r_x0 - CW'(1);
                    py = r_y0 + CW'(1);
                    pt_ok = (r_x0 != '0);
                end
                3'd3: begin
                    py = r_y0 - CW'(1);
                    pt_ok = (r_y0 != '0);
                end
                3'd4: py = r_y0 + CW'(1);
                3'd5: begin
                    px = r_x0 + CW'(1);
                    py = r_y0 - CW'(1);
                    pt_ok = (r_y0 != '0);
                end
                3'd6: px = r_x0 + CW'(1);
                default: begin
                    px = r_x0 + CW'(1);
                    py = r_y0 + CW'(1);
                end
            endcase
        end else begin
            case (r_phase)
                PH_EDGE_Y0: px = r_k[0] ? x1 : r_x0;
                PH_EDGE_Y1: begin
                    px = r_k[0] ? x1 : r_x0;
                    py = y1;
                end
                PH_EDGE_X0: py = r_k[0] ? y1 : r_y0;
                PH_EDGE_X1: begin
                    px = x1;
                    py = r_k[0] ? y1 : r_y0;
                end
                default: begin
                    px = r_k[0] ? x1 : r_x0;
                    py = r_k[1] ? y1 : r_y0;
                end
            endcase
        end
    end

    // Read coordinates saturate at the far edge of the map.
    always_comb begin
        xe = XW'(i_in.coord_x);
        ye = XW'(i_in.coord_y);
        sx = (xe > XW'(GRID_SIZE)) ? GRID : CW'(xe);
        sy = (ye > XW'(GRID_SIZE)) ? GRID : CW'(ye);
    end

    // Memory read port.
    always_comb begin
        mem_ren = 1'b0;
        raddr   = addr_of(px, py);
        if (r_state == S_IDLE) begin
            mem_ren = in_acc && (t_cmd'(i_in.cmd) == CMD_READ);
            raddr   = addr_of(sx, sy);
        end else if (r_state == S_GATHER) begin
            mem_ren = (r_k < n_pts) && pt_ok;
        end
    end

    // Memory write port: corners on transfer, other points after the arithmetic.
    always_comb begin
        mem_we = 1'b0;
        waddr  = addr_of(mx, my);
        wdata  = gen_height;
        if (r_state == S_IDLE) begin
            mem_we = in_acc && (t_cmd'(i_in.cmd) == CMD_RAND) && !r_done
                   && (r_phase == PH_CORNER);
            waddr  = addr_of(r_corner[0] ? GRID : '0, r_corner[1] ? GRID : '0);
            wdata  = i_in.rand_value;
        end else if (r_state == S_WRITE) begin
            mem_we = 1'b1;
            if (r_smooth) begin
                waddr = addr_of(r_x0, r_y0);
                wdata = smooth_height;
            end else begin
                case (r_phase)
                    PH_EDGE_Y0: waddr = addr_of(mx, r_y0);
                    PH_EDGE_Y1: waddr = addr_of(mx, y1);
                    PH_EDGE_X0: waddr = addr_of(r_x0, my);
                    PH_EDGE_X1: waddr = addr_of(x1, my);
                    default:    waddr = addr_of(mx, my);
                endcase
            end
        end
    end

    // Height memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        if (mem_ren) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // Control word for the arithmetic unit.
    always_comb begin
        alu_ctl.acc_clr   = (r_state == S_IDLE) || (r_state == S_WRITE)
                          || (r_state == S_LEVEL_LOAD);
        alu_ctl.acc_en    = r_pv;
        alu_ctl.mul_en    = (r_state == S_MUL) || (r_state == S_LEVEL);
        alu_ctl.mul_src   = (r_state == S_LEVEL) ? MS_LEVEL : (r_smooth ? MS_DIV : MS_DISP);
        alu_ctl.mean_en   = (r_state == S_MUL);
        alu_ctl.mean_four = (r_phase == PH_CENTRE) || (r_phase == PH_MID);
        if (r_x0 == '0 && r_y0 == '0) begin
            alu_ctl.wsel = W_THREE;
        end else if (r_x0 == '0 || r_y0 == '0) begin
            alu_ctl.wsel = W_FIVE;
        end else begin
            alu_ctl.wsel = W_EIGHT;
        end
    end

    mdh_alu u_alu (
        .i_clk           (i_clk),
        .i_ctl           (alu_ctl),
        .i_rdata         (r_rdata),
        .i_rand          (r_rand),
        .i_noise         (r_noise),
        .i_disp          (d_eff),
        .o_gen_height    (gen_height),
        .o_smooth_height (smooth_height),
        .o_level_disp    (level_disp)
    );

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_CORNER;
            r_corner    <= '0;
            r_x0        <= '0;
            r_y0        <= '0;
            r_side      <= CW'(GRID_SIZE / 2);
            r_d         <= DISP_W'(NOISE_RESET);
            r_pass      <= '0;
            r_done      <= 1'b0;
            r_smooth    <= 1'b0;
            r_k         <= '0;
            r_pv        <= 1'b0;
            r_noise     <= NOISE_RESET;
            r_blur      <= BLUR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NOISE: r_noise <= i_cfg_data;
                    CFG_BLUR:  r_blur  <= i_cfg_data[BLUR_W-1:0];
                    default:   r_noise <= r_noise;
                endcase
            end

            r_pv <= mem_ren && (r_state == S_GATHER);

            // The read delivery state refills the register itself.
            if (r_out_valid && o_out.ready && r_state != S_RDOUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rand <= i_in.rand_value;
                        r_k    <= '0;
                        case (t_cmd'(i_in.cmd))
                            CMD_RAND: begin
                                if (!r_done) begin
                                    if (r_phase == PH_CORNER) begin
                                        r_corner <= r_corner + 2'd1;
                                        if (r_corner == 2'd3) begin
                                            r_phase <= PH_CENTRE;
                                        end
                                    end else begin
                                        r_state <= S_GATHER;
                                    end
                                end
                            end
                            CMD_READ: r_state <= S_RDOUT;
                            CMD_RESTART: begin
                                r_phase  <= PH_CORNER;
                                r_corner <= '0;
                                r_x0     <= '0;
                                r_y0     <= '0;
                                r_side   <= CW'(GRID_SIZE / 2);
                                r_d      <= DISP_W'(r_noise);
                                r_pass   <= '0;
                                r_done   <= 1'b0;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end

                S_RDOUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_height   <= r_rdata;
                        r_out_complete <= r_done;
                        r_state        <= S_IDLE;
                    end
                end

                S_GATHER: begin
                    if (r_k == n_pts) begin
                        r_state <= S_MUL;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end

                S_MUL: r_state <= S_WRITE;

                S_WRITE: begin
                    r_k <= '0;
                    if (r_smooth) begin
                        // Raster walk over points below the far row and column.
                        r_state <= S_GATHER;
                        if (r_y0 == GRID - CW'(1)) begin
                            r_y0 <= '0;
                            if (r_x0 == GRID - CW'(1)) begin
                                r_x0 <= '0;
                                if (r_pass == r_blur - BLUR_W'(1)) begin
                                    r_smooth <= 1'b0;
                                    r_done   <= 1'b1;
                                    r_state  <= S_IDLE;
                                end else begin
                                    r_pass <= r_pass + BLUR_W'(1);
                                end
                            end else begin
                                r_x0 <= r_x0 + CW'(1);
                            end
                        end else begin
                            r_y0 <= r_y0 + CW'(1);
                        end
                    end else begin
                        r_state <= S_IDLE;
                        case (r_phase)
                            PH_CENTRE: begin
                                r_d     <= DISP_W'(r_noise);
                                r_side  <= CW'(GRID_SIZE / 2);
                                r_x0    <= '0;
                                r_y0    <= '0;
                                r_phase <= PH_MID;
                            end
                            PH_MID:     r_phase <= PH_EDGE_Y0;
                            PH_EDGE_Y0: r_phase <= PH_EDGE_Y1;
                            PH_EDGE_Y1: r_phase <= PH_EDGE_X0;
                            PH_EDGE_X0: r_phase <= PH_EDGE_X1;
                            PH_EDGE_X1: begin
                                // Next cell, next row of cells, or next level.
                                r_phase <= PH_MID;
                                if (y1 == GRID) begin
                                    r_y0 <= '0;
                                    if (x1 == GRID) begin
                                        r_x0    <= '0;
                                        r_side  <= r_side >> 1;
                                        r_state <= S_LEVEL;
                                    end else begin
                                        r_x0 <= x1;
                                    end
                                end else begin
                                    r_y0 <= y1;
                                end
                            end
                            default: r_phase <= r_phase;
                        endcase
                    end
                end

                S_LEVEL: r_state <= S_LEVEL_LOAD;

                S_LEVEL_LOAD: begin
                    r_d     <= level_disp;
                    r_state <= S_IDLE;
                    if (r_side < CW'(2)) begin
                        if (r_blur == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_smooth <= 1'b1;
                            r_pass   <= '0;
                            r_x0     <= '0;
                            r_y0     <= '0;
                            r_k      <= '0;
                            r_state  <= S_GATHER;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The gather sweep only reads and the write step only writes.
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_ren))
        else $error("height memory read and written in the same cycle");

    // A result appears only from the read delivery state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RDOUT))
        else $error("result produced outside a read");

    // The map is never marked complete while smoothing runs.
    a_smooth_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GATHER && r_smooth) |-> !r_done)
        else $error("complete flag set during smoothing");

    // The cell side never collapses to zero.
    a_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side != '0)
        else $error("cell side is zero");

    // The gather counter stays within the point list.
    a_gather: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GATHER) |-> (r_k <= n_pts))
        else $error("gather step beyond point list");

endmodule

`default_nettype wire
